/* rtl/olard_pkg.sv */
package olard_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_REMOVED  = 3'd0,
        KIND_NOTFOUND = 3'd1,
        KIND_ENTRY    = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_FULL     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } t_state;

endpackage

/* rtl/ordered_list_append_remove_dump_unit.sv */
// Bounded ordered list of DEPTH 32-bit order numbers held in one synchronous RAM
// (one write port, one read port with registered data). An input transfer is taken
// only while the unit is idle. An append gives no result unless the list is full; an
// append to a full list gives its single result. A remove reads the list from the head,
// one entry a cycle, until the first match or the tail. On a match it then moves each
// later entry down by one place, also one entry a cycle, and in both cases it gives its
// single result. A dump gives one result per entry, head to tail, one a cycle while the
// output is not stalled. An empty list gives a single result. These rates are set by the
// single read port of the list RAM. One output register sits between the unit and the
// output channel.
module ordered_list_append_remove_dump_unit
    import olard_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic signed [31:0] o_entry_value,
    output logic               o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [31:0]   r_value, n_value;
    t_kind         r_rkind, n_rkind;

    logic          r_out_valid;
    t_kind         r_out_kind;
    logic [31:0]   r_out_value;
    logic          r_out_last;

    logic          w_accept;
    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic          w_is_last;
    logic          w_hit;
    logic [CW-1:0] w_ptr_inc;
    logic [CW-1:0] w_ptr_dec;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          out_load;
    t_kind         out_kind;
    logic [31:0]   out_value;
    logic          out_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ptr_inc  = r_ptr + CW'(1);
    assign w_ptr_dec  = r_ptr - CW'(1);
    assign w_is_last  = (w_ptr_inc == r_count);
    assign w_hit      = (r_rd_data == r_value);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_APPEND: n_state = w_full ? S_RESP : S_IDLE;
                        OP_REMOVE: n_state = w_empty ? S_RESP : S_SEARCH;
                        OP_DUMP:   n_state = w_empty ? S_RESP : S_DUMP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_is_last) begin
                    n_state = S_RESP;
                end else if (w_hit) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_is_last) begin
                    n_state = S_RESP;
                end
            end
            S_DUMP: begin
                if (w_out_free && w_is_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_value   = r_value;
        n_rkind   = r_rkind;
        rd_en     = 1'b0;
        rd_addr   = w_ptr_inc[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = i_value;
        out_load  = 1'b0;
        out_kind  = r_rkind;
        out_value = r_value;
        out_last  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value = i_value;
                    n_ptr   = '0;
                    rd_addr = '0;
                    case (i_op)
                        OP_APPEND: begin
                            if (w_full) begin
                                n_rkind = KIND_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            n_rkind = KIND_NOTFOUND;
                            rd_en   = !w_empty;
                        end
                        OP_DUMP: begin
                            n_rkind = KIND_EMPTY;
                            rd_en   = !w_empty;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_rkind = KIND_REMOVED;
                end
                if (w_is_last) begin
                    if (w_hit) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    rd_en = 1'b1;
                    n_ptr = w_ptr_inc;
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = w_ptr_dec[AW-1:0];
                wr_data = r_rd_data;
                if (w_is_last) begin
                    n_count = r_count - CW'(1);
                end else begin
                    rd_en = 1'b1;
                    n_ptr = w_ptr_inc;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    out_load  = 1'b1;
                    out_kind  = KIND_ENTRY;
                    out_value = r_rd_data;
                    out_last  = w_is_last;
                    if (!w_is_last) begin
                        rd_en = 1'b1;
                        n_ptr = w_ptr_inc;
                    end
                end
            end
            S_RESP: begin
                out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // list ram
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_value <= n_value;
        r_rkind <= n_rkind;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_value <= out_value;
            r_out_last  <= out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_entry_value = r_out_value;
    assign o_last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    a_ptr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_SHIFT || r_state == S_DUMP) |-> r_ptr < r_count)
        else $error("walk pointer beyond list tail");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_APPEND && !w_full) |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not grow the list");

    a_shift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_is_last) |=> r_count == $past(r_count) - CW'(1))
        else $error("remove did not shrink the list");

    a_dump_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && w_out_free) |=> (r_out_valid && r_out_kind == KIND_ENTRY))
        else $error("dump entry not presented");

endmodule
